// File: design/assert_macros.svh
// Assertion macros used by the top level of the vertex transform.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property checked at every rising edge of clk, quiet while arst_n is low.
`define HVT_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);

// When the trigger holds, the outcome must hold in the next cycle.
`define HVT_ASSERT_NEXT(lbl, trig, outcome, msg) \
	`HVT_ASSERT(lbl, (trig) |=> (outcome), msg)

// When the trigger holds, the outcome must hold in the same cycle.
`define HVT_ASSERT_SAME(lbl, trig, outcome, msg) \
	`HVT_ASSERT(lbl, (trig) |-> (outcome), msg)

`endif

// File: design/hvt_pkg.sv
// Package with the shared types and constants of the vertex transform.
`default_nettype none

package hvt_pkg;

	// Default number of fraction bits of coefficients and components.
	localparam int HVT_FRAC_BITS = 16;

	// Width of one coefficient or vector component.
	localparam int HVT_DATA_W = 32;

	// Matrix register file shape.
	localparam int HVT_NUM_REGS  = 8;
	localparam int HVT_REG_W     = 64;
	localparam int HVT_REG_IDX_W = $clog2(HVT_NUM_REGS);

	// Register indexes of the matrix registers.
	typedef enum logic [HVT_REG_IDX_W-1:0] {
		REG_ROW0_C01 = 3'd0,
		REG_ROW0_C23 = 3'd1,
		REG_ROW1_C01 = 3'd2,
		REG_ROW1_C23 = 3'd3,
		REG_ROW2_C01 = 3'd4,
		REG_ROW2_C23 = 3'd5,
		REG_ROW3_C01 = 3'd6,
		REG_ROW3_C23 = 3'd7
	} hvt_reg_t;

	// Load enables of the pipeline stages inside a row unit.
	typedef struct packed {
		logic s2;
		logic s3;
		logic s4;
	} hvt_adv_t;

endpackage

`default_nettype wire

// File: design/homogeneous_vertex_transform.sv
// Top level of the 4x4 matrix by homogeneous vector transform.
//
//   channel   direction   handshake               payload
//   in        input       in_valid / in_stall     vec_x, vec_y, vec_z, vec_w
//   out       output      out_valid / out_stall   out_x, out_y, out_z, out_w, overflow
//   cfg       input       cfg_we                  cfg_index, cfg_data
//
// One item is accepted per cycle while in_stall is low; its result passes the
// input register, multiply, shift and pair add, and final add and saturate
// stages and waits in the stage 4 registers until out_stall is low.
// The four-stage pipeline is built around the 16 multipliers.
// Reset loads the identity matrix and empties the pipeline; there is no
// clearing pass. A stall holds the output register, and each stage keeps its
// item until the next stage frees up, so up to four items wait in flight.
`default_nettype none

module homogeneous_vertex_transform
	import hvt_pkg::*;
#(
	parameter int FRAC_BITS = HVT_FRAC_BITS
) (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	input  wire logic                         in_valid,
	output logic                              in_stall,
	input  wire logic signed [HVT_DATA_W-1:0] vec_x,
	input  wire logic signed [HVT_DATA_W-1:0] vec_y,
	input  wire logic signed [HVT_DATA_W-1:0] vec_z,
	input  wire logic signed [HVT_DATA_W-1:0] vec_w,
	output logic                              out_valid,
	input  wire logic                         out_stall,
	output logic signed [HVT_DATA_W-1:0]      out_x,
	output logic signed [HVT_DATA_W-1:0]      out_y,
	output logic signed [HVT_DATA_W-1:0]      out_z,
	output logic signed [HVT_DATA_W-1:0]      out_w,
	output logic                              overflow,
	input  wire logic                         cfg_we,
	input  wire logic [HVT_REG_IDX_W-1:0]     cfg_index,
	input  wire logic [HVT_REG_W-1:0]         cfg_data
);

	`include "assert_macros.svh"

	// Identity coefficient in the low and in the high half of a register.
	localparam logic [HVT_REG_W-1:0] ONE_LO = HVT_REG_W'(1) << FRAC_BITS;
	localparam logic [HVT_REG_W-1:0] ONE_HI = ONE_LO << HVT_DATA_W;

	logic [HVT_REG_W-1:0]         cfg_q [HVT_NUM_REGS];
	logic [3:0][HVT_DATA_W-1:0]   vec_s1;
	logic                         valid_s1, valid_s2, valid_s3, valid_s4;
	logic                         ready_s1, ready_s2, ready_s3, ready_s4;
	logic                         pipe_full;
	hvt_adv_t                     adv;
	logic [3:0][HVT_DATA_W-1:0]   res;
	logic [3:0]                   sat;

	// Matrix registers, identity after reset.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q[REG_ROW0_C01] <= ONE_LO;
			cfg_q[REG_ROW0_C23] <= '0;
			cfg_q[REG_ROW1_C01] <= ONE_HI;
			cfg_q[REG_ROW1_C23] <= '0;
			cfg_q[REG_ROW2_C01] <= '0;
			cfg_q[REG_ROW2_C23] <= ONE_LO;
			cfg_q[REG_ROW3_C01] <= '0;
			cfg_q[REG_ROW3_C23] <= ONE_HI;
		end else if (cfg_we) begin
			cfg_q[cfg_index] <= cfg_data;
		end
	end

	// A stage takes a new item when it is empty or its item moves on.
	assign ready_s4 = !valid_s4 || !out_stall;
	assign ready_s3 = !valid_s3 || ready_s4;
	assign ready_s2 = !valid_s2 || ready_s3;
	assign ready_s1 = !valid_s1 || ready_s2;
	assign in_stall = !ready_s1;

	assign adv.s2 = ready_s2;
	assign adv.s3 = ready_s3;
	assign adv.s4 = ready_s4;

	// Valid bits travel with the items.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
			valid_s4 <= 1'b0;
		end else begin
			if (ready_s1) valid_s1 <= in_valid;
			if (ready_s2) valid_s2 <= valid_s1;
			if (ready_s3) valid_s3 <= valid_s2;
			if (ready_s4) valid_s4 <= valid_s3;
		end
	end

	// Stage 1: input register for the vector.
	always_ff @(posedge clk) begin
		if (ready_s1) begin
			vec_s1[0] <= vec_x;
			vec_s1[1] <= vec_y;
			vec_s1[2] <= vec_z;
			vec_s1[3] <= vec_w;
		end
	end

	// One row unit per output component.
	for (genvar r = 0; r < 4; r++) begin : g_row
		logic [3:0][HVT_DATA_W-1:0] coef_row;

		assign coef_row[0] = cfg_q[2*r][HVT_DATA_W-1:0];
		assign coef_row[1] = cfg_q[2*r][HVT_REG_W-1:HVT_DATA_W];
		assign coef_row[2] = cfg_q[2*r+1][HVT_DATA_W-1:0];
		assign coef_row[3] = cfg_q[2*r+1][HVT_REG_W-1:HVT_DATA_W];

		hvt_row #(
			.FRAC_BITS(FRAC_BITS)
		) u_row (
			.clk  (clk),
			.adv  (adv),
			.coef (coef_row),
			.vec  (vec_s1),
			.res  (res[r]),
			.sat  (sat[r])
		);
	end

	// Result outputs straight from the stage 4 registers.
	assign out_valid = valid_s4;
	assign out_x     = res[0];
	assign out_y     = res[1];
	assign out_z     = res[2];
	assign out_w     = res[3];
	assign overflow  = |sat;

	// Every stage holds an item behind a stalled result.
	assign pipe_full = out_stall && valid_s4 && valid_s3 && valid_s2 && valid_s1;

	// An accepted item always lands in the input stage.
	`HVT_ASSERT_NEXT(a_accept_lands, in_valid && !in_stall, valid_s1, "accepted item lost")

	// A full pipeline behind a stalled result must push back on the input.
	`HVT_ASSERT_SAME(a_full_stalls, pipe_full, in_stall, "full pipeline not stalling input")

	// An item waiting behind a stalled result is not dropped.
	`HVT_ASSERT_NEXT(a_s3_holds, valid_s3 && valid_s4 && out_stall, valid_s3, "stage 3 item dropped during stall")

endmodule

`default_nettype wire

// File: design/hvt_row.sv
// One matrix row: four multiplies, floor shift, adder tree and saturation.
`default_nettype none

module hvt_row
	import hvt_pkg::*;
#(
	parameter int FRAC_BITS = HVT_FRAC_BITS
) (
	input  wire logic                               clk,
	input  wire hvt_adv_t                           adv,
	input  wire logic [3:0][HVT_DATA_W-1:0]         coef,
	input  wire logic [3:0][HVT_DATA_W-1:0]         vec,
	output logic signed [HVT_DATA_W-1:0]            res,
	output logic                                    sat
);

	localparam int PROD_W = 2 * HVT_DATA_W;
	localparam int PAIR_W = PROD_W + 1;
	localparam int SUM_W  = PROD_W + 2;

	localparam logic signed [SUM_W-1:0] SAT_MAX =
		SUM_W'(signed'({1'b0, {(HVT_DATA_W-1){1'b1}}}));
	localparam logic signed [SUM_W-1:0] SAT_MIN =
		SUM_W'(signed'({1'b1, {(HVT_DATA_W-1){1'b0}}}));

	logic signed [PROD_W-1:0] prod_s2 [4];
	logic signed [PAIR_W-1:0] pair_s3 [2];
	logic signed [SUM_W-1:0]  sum;
	logic signed [HVT_DATA_W-1:0] res_s4;
	logic                         sat_s4;

	// Stage 2: exact signed products of coefficient and component.
	always_ff @(posedge clk) begin
		if (adv.s2) begin
			for (int j = 0; j < 4; j++) begin
				prod_s2[j] <= PROD_W'($signed(coef[j]) * $signed(vec[j]));
			end
		end
	end

	// Stage 3: shift each product down with floor rounding, add in pairs.
	always_ff @(posedge clk) begin
		if (adv.s3) begin
			for (int k = 0; k < 2; k++) begin
				pair_s3[k] <= PAIR_W'(prod_s2[2*k] >>> FRAC_BITS) +
					PAIR_W'(prod_s2[2*k+1] >>> FRAC_BITS);
			end
		end
	end

	// Final sum of the row, exact before saturation.
	assign sum = SUM_W'(pair_s3[0]) + SUM_W'(pair_s3[1]);

	// Stage 4: saturate to the component width and flag the clip.
	always_ff @(posedge clk) begin
		if (adv.s4) begin
			if (sum > SAT_MAX) begin
				res_s4 <= SAT_MAX[HVT_DATA_W-1:0];
				sat_s4 <= 1'b1;
			end else if (sum < SAT_MIN) begin
				res_s4 <= SAT_MIN[HVT_DATA_W-1:0];
				sat_s4 <= 1'b1;
			end else begin
				res_s4 <= sum[HVT_DATA_W-1:0];
				sat_s4 <= 1'b0;
			end
		end
	end

	assign res = res_s4;
	assign sat = sat_s4;

endmodule

`default_nettype wire
